### sv/cpt_pkg.sv
// Shared widths, latencies and region codes for the closest-point-on-triangle pipeline.
package cpt_pkg;

  // Coordinate and intermediate widths (all signed, Q16.16 based).
  localparam int unsigned CoordW     = 32;
  localparam int unsigned DiffW      = 33;
  localparam int unsigned DotPW      = 66;
  localparam int unsigned DotW       = 68;
  localparam int unsigned VolPW      = 136;
  localparam int unsigned VolW       = 137;
  localparam int unsigned NumPW      = 170;
  localparam int unsigned NumW       = 171;
  localparam int unsigned DenW       = 139;
  localparam int unsigned QuotW      = 42;
  localparam int unsigned QuotLimBit = 40;
  localparam int unsigned SumW       = 43;

  // Largest quotient magnitude that is passed on.
  localparam logic [QuotW-1:0] QuotMax = QuotW'(1) << QuotLimBit;

  // Pipeline latencies of the arithmetic units.
  localparam int unsigned LatMulDot = ((DiffW + 31) / 32) * ((DiffW + 31) / 32) + 3;
  localparam int unsigned LatMulV   = ((DotW + 31) / 32) * ((DotW + 31) / 32) + 3;
  localparam int unsigned LatMulNum = ((VolW + 31) / 32) * ((DiffW + 31) / 32) + 3;
  localparam int unsigned LatDiv    = QuotW + 2;
  localparam int unsigned LatTotal  = LatMulDot + LatMulV + LatMulNum + LatDiv + 7;

  // Feature of the triangle that holds the closest point.
  typedef enum logic [2:0] {
    RegVertA    = 3'd0,
    RegVertB    = 3'd1,
    RegEdgeAB   = 3'd2,
    RegVertC    = 3'd3,
    RegEdgeAC   = 3'd4,
    RegEdgeBC   = 3'd5,
    RegInterior = 3'd6,
    RegDegen    = 3'd7
  } region_e;

endpackage

### sv/cpt_dly.sv
// Enabled shift-register delay line for side data that travels with the pipeline.
module cpt_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  // Each tap moves one place on every enabled cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule

### sv/cpt_mul.sv
// Pipelined signed multiplier built from one 32x32 partial product per stage.
module cpt_mul #(
  parameter int unsigned WA = cpt_pkg::DiffW,
  parameter int unsigned WB = cpt_pkg::DiffW
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [WA-1:0]   a_i,
  input  logic signed [WB-1:0]   b_i,
  output logic signed [WA+WB-1:0] p_o
);

  localparam int unsigned NA  = (WA + 31) / 32;
  localparam int unsigned NB  = (WB + 31) / 32;
  localparam int unsigned NP  = NA * NB;
  localparam int unsigned WP  = WA + WB;
  localparam int unsigned WAP = NA * 32;
  localparam int unsigned WBP = NB * 32;

  logic [WA-1:0]  a_mag;
  logic [WB-1:0]  b_mag;
  logic [WAP-1:0] am_q  [NP];
  logic [WBP-1:0] bm_q  [NP];
  logic           sg_q  [NP+1];
  logic [WP-1:0]  acc_q [NP+1];
  logic [WP-1:0]  pp_q  [NP+1];
  logic [WP-1:0]  sum_q;
  logic           sgf_q;

  // Magnitudes; the most negative value maps onto its unsigned pattern.
  assign a_mag = a_i[WA-1] ? WA'(~a_i + 1'b1) : WA'(a_i);
  assign b_mag = b_i[WB-1] ? WB'(~b_i + 1'b1) : WB'(b_i);

  // Operand capture.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      am_q[0]  <= WAP'(a_mag);
      bm_q[0]  <= WBP'(b_mag);
      sg_q[0]  <= a_i[WA-1] ^ b_i[WB-1];
      acc_q[0] <= '0;
      pp_q[0]  <= '0;
    end
  end

  // One partial product per stage while the previous one is accumulated.
  for (genvar s = 1; s <= NP; s++) begin : g_pp
    localparam int unsigned IA = (s - 1) / NB;
    localparam int unsigned IB = (s - 1) % NB;
    logic [63:0]    prod;
    logic [WP+63:0] prod_sh;

    assign prod    = am_q[s-1][IA*32 +: 32] * bm_q[s-1][IB*32 +: 32];
    assign prod_sh = {WP'(0), prod} << ((IA + IB) * 32);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sg_q[s]  <= sg_q[s-1];
        acc_q[s] <= acc_q[s-1] + pp_q[s-1];
        pp_q[s]  <= prod_sh[WP-1:0];
      end
    end

    if (s < NP) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          am_q[s] <= am_q[s-1];
          bm_q[s] <= bm_q[s-1];
        end
      end
    end
  end

  // Last accumulation, then the sign is applied.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= acc_q[NP] + pp_q[NP];
      sgf_q <= sg_q[NP];
      p_o   <= sgf_q ? WP'(~sum_q + 1'b1) : sum_q;
    end
  end

endmodule

### sv/cpt_div.sv
// Pipelined restoring divider: rounded quotient, ties away from zero, clamped to 2^40.
module cpt_div #(
  parameter int unsigned WN = cpt_pkg::NumW,
  parameter int unsigned WD = cpt_pkg::DenW
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [WN-1:0]             num_i,
  input  logic signed [WD-1:0]             den_i,
  output logic signed [cpt_pkg::QuotW-1:0] quo_o
);

  localparam int unsigned QW = cpt_pkg::QuotW;
  localparam int unsigned WR = (WN + 2 > WD + QW) ? WN + 2 : WD + QW;

  logic [WN-1:0] n_mag;
  logic [WD-1:0] d_mag;
  logic [WR-1:0] r_q   [QW];
  logic [WR-1:0] d_q   [QW];
  logic [QW-1:0] q_q   [QW+1];
  logic          neg_q [QW+1];
  logic [QW-1:0] mag;

  assign n_mag = num_i[WN-1] ? WN'(~num_i + 1'b1) : WN'(num_i);
  assign d_mag = den_i[WD-1] ? WD'(~den_i + 1'b1) : WD'(den_i);

  // Rounding is folded in: floor((2|n| + |d|) / (2|d|)).
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= (WR'(n_mag) << 1) + WR'(d_mag);
      d_q[0]   <= WR'(d_mag) << 1;
      q_q[0]   <= '0;
      neg_q[0] <= num_i[WN-1] ^ den_i[WD-1];
    end
  end

  // One quotient bit per stage, most significant first. A set top bit means overflow.
  for (genvar s = 1; s <= QW; s++) begin : g_bit
    localparam int unsigned K = QW - s;
    logic [WR-1:0] dsh;
    logic          ge;

    assign dsh = d_q[s-1] << K;
    assign ge  = (r_q[s-1] >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[s]   <= {q_q[s-1][QW-2:0], ge};
        neg_q[s] <= neg_q[s-1];
      end
    end

    if (s < QW) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[s] <= ge ? r_q[s-1] - dsh : r_q[s-1];
          d_q[s] <= d_q[s-1];
        end
      end
    end
  end

  // Clamp the magnitude and restore the sign.
  assign mag = (q_q[QW] > cpt_pkg::QuotMax) ? cpt_pkg::QuotMax : q_q[QW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= neg_q[QW] ? QW'(~mag + 1'b1) : mag;
    end
  end

endmodule

### sv/closest_point_on_triangle.sv
// Top level of the closest-point-on-triangle pipeline.
//
//   Channel | Handshake               | Beat contents
//   --------+-------------------------+-------------------------------------------
//   input   | in_valid_i / in_stall_o | vert_a/b/c_x/y/z_i, query_x/y/z_i (Q16.16)
//   output  | out_valid_o/out_stall_i | near_x/y/z_o (Q16.16), region_o
//
// One beat is accepted per cycle while in_stall_o is low; results leave in input order.
// The latency is set by the chained multipliers (one 32x32 partial product per
// stage) and the 42-stage rounding divider.
// Reset clears only the valid bits; no clearing pass is needed.
// A stalled output beat holds the whole pipeline, and the input is stalled then.
module closest_point_on_triangle (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  vert_a_x_i,
  input  logic signed [31:0]  vert_a_y_i,
  input  logic signed [31:0]  vert_a_z_i,
  input  logic signed [31:0]  vert_b_x_i,
  input  logic signed [31:0]  vert_b_y_i,
  input  logic signed [31:0]  vert_b_z_i,
  input  logic signed [31:0]  vert_c_x_i,
  input  logic signed [31:0]  vert_c_y_i,
  input  logic signed [31:0]  vert_c_z_i,
  input  logic signed [31:0]  query_x_i,
  input  logic signed [31:0]  query_y_i,
  input  logic signed [31:0]  query_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  near_x_o,
  output logic signed [31:0]  near_y_o,
  output logic signed [31:0]  near_z_o,
  output logic [2:0]          region_o
);

  localparam int unsigned CW  = cpt_pkg::CoordW;
  localparam int unsigned DfW = cpt_pkg::DiffW;
  localparam int unsigned DtW = cpt_pkg::DotW;
  localparam int unsigned VW  = cpt_pkg::VolW;
  localparam int unsigned NW  = cpt_pkg::NumW;
  localparam int unsigned DnW = cpt_pkg::DenW;
  localparam int unsigned QW  = cpt_pkg::QuotW;
  localparam int unsigned SW  = cpt_pkg::SumW;
  localparam int unsigned D1W = DtW + 1;
  localparam int unsigned D2W = DtW + 2;
  localparam int unsigned TL  = cpt_pkg::LatTotal;
  localparam int unsigned SideW = 3 * CW + 3 + 1;

  logic en;
  logic [TL-1:0] vld_q;

  logic signed [CW-1:0]  in_a [3];
  logic signed [CW-1:0]  in_b [3];
  logic signed [CW-1:0]  in_c [3];
  logic signed [CW-1:0]  in_p [3];

  // Stage 1: edge and offset vectors.
  logic signed [DfW-1:0] ab_q [3];
  logic signed [DfW-1:0] ac_q [3];
  logic signed [DfW-1:0] ap_q [3];
  logic signed [DfW-1:0] bp_q [3];
  logic signed [DfW-1:0] cp_q [3];
  logic signed [DfW-1:0] bc_q [3];
  logic signed [CW-1:0]  a_q  [3];
  logic signed [CW-1:0]  b_q  [3];
  logic signed [CW-1:0]  c_q  [3];

  logic signed [DfW-1:0]           du [6][3];
  logic signed [DfW-1:0]           dv [6][3];
  logic signed [cpt_pkg::DotPW-1:0] dp [6][3];
  logic signed [DtW-1:0]           d_q [6];

  logic signed [cpt_pkg::VolPW-1:0] vp [6];
  logic signed [VW-1:0]            v_q [3];

  logic [6*DtW-1:0]  d_flat;
  logic [6*DtW-1:0]  dd_flat;
  logic signed [DtW-1:0] dd [6];

  logic [9*DfW-1:0]  df_flat;
  logic [9*DfW-1:0]  dfl_flat;
  logic [9*CW-1:0]   cr_flat;
  logic [9*CW-1:0]   crl_flat;
  logic signed [DfW-1:0] dfl [3][3];
  logic signed [CW-1:0]  crl [3][3];

  // Region stage.
  logic signed [D1W-1:0] t_w;
  logic signed [D1W-1:0] e5_w;
  logic signed [D1W-1:0] dab_w;
  logic signed [D1W-1:0] dac_w;
  logic signed [D2W-1:0] dbc_w;
  logic signed [DnW-1:0] din_w;
  cpt_pkg::region_e      r1_code_d, r1_code_q;
  logic signed [DnW-1:0] r1_den_d, r1_den_q;
  logic signed [VW-1:0]  r1_x1_d, r1_x1_q;
  logic signed [VW-1:0]  r1_x2_d, r1_x2_q;

  // Operand selection stage.
  cpt_pkg::region_e      r2_code_d, r2_code_q;
  logic                  r2_addq_d, r2_addq_q;
  logic [1:0]            r2_esel;
  logic [1:0]            r2_bsel;
  logic signed [DfW-1:0] r2_e1_q [3];
  logic signed [DfW-1:0] r2_e2_q [3];
  logic signed [CW-1:0]  r2_base_q [3];
  logic signed [VW-1:0]  r2_x1_q;
  logic signed [VW-1:0]  r2_x2_q;
  logic signed [DnW-1:0] r2_den_q;
  logic                  den_zero;

  logic signed [cpt_pkg::NumPW-1:0] m1 [3];
  logic signed [cpt_pkg::NumPW-1:0] m2 [3];
  logic signed [NW-1:0]             num_q [3];
  logic [DnW-1:0]                   den_l;
  logic signed [QW-1:0]             quo [3];

  logic [SideW-1:0] side_d;
  logic [SideW-1:0] side_l;
  logic signed [CW-1:0] base_l [3];
  logic [2:0]           code_l;
  logic                 addq_l;
  logic signed [SW-1:0] sum_w [3];
  logic signed [CW-1:0] sat_w [3];

  // Global advance: the pipeline moves unless a finished beat is held.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TL-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[TL-1];

  assign in_a = '{vert_a_x_i, vert_a_y_i, vert_a_z_i};
  assign in_b = '{vert_b_x_i, vert_b_y_i, vert_b_z_i};
  assign in_c = '{vert_c_x_i, vert_c_y_i, vert_c_z_i};
  assign in_p = '{query_x_i, query_y_i, query_z_i};

  // Stage 1: exact 33-bit differences.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ab_q[i] <= DfW'(in_b[i]) - DfW'(in_a[i]);
        ac_q[i] <= DfW'(in_c[i]) - DfW'(in_a[i]);
        ap_q[i] <= DfW'(in_p[i]) - DfW'(in_a[i]);
        bp_q[i] <= DfW'(in_p[i]) - DfW'(in_b[i]);
        cp_q[i] <= DfW'(in_p[i]) - DfW'(in_c[i]);
        bc_q[i] <= DfW'(in_c[i]) - DfW'(in_b[i]);
        a_q[i]  <= in_a[i];
        b_q[i]  <= in_b[i];
        c_q[i]  <= in_c[i];
      end
    end
  end

  // Operands of d1..d6: (ab,ap) (ac,ap) (ab,bp) (ac,bp) (ab,cp) (ac,cp).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      du[0][i] = ab_q[i];  dv[0][i] = ap_q[i];
      du[1][i] = ac_q[i];  dv[1][i] = ap_q[i];
      du[2][i] = ab_q[i];  dv[2][i] = bp_q[i];
      du[3][i] = ac_q[i];  dv[3][i] = bp_q[i];
      du[4][i] = ab_q[i];  dv[4][i] = cp_q[i];
      du[5][i] = ac_q[i];  dv[5][i] = cp_q[i];
    end
  end

  for (genvar k = 0; k < 6; k++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_ax
      cpt_mul #(.WA(DfW), .WB(DfW)) u_mul (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (du[k][i]),
        .b_i   (dv[k][i]),
        .p_o   (dp[k][i])
      );
    end
  end

  // Stage 2: dot products summed.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        d_q[k] <= DtW'(dp[k][0]) + DtW'(dp[k][1]) + DtW'(dp[k][2]);
      end
    end
  end

  // Barycentric products: va = d3*d6 - d5*d4, vb = d5*d2 - d1*d6, vc = d1*d4 - d3*d2.
  cpt_mul #(.WA(DtW), .WB(DtW)) u_va0 (
    .clk_i (clk_i), .en_i (en), .a_i (d_q[2]), .b_i (d_q[5]), .p_o (vp[0]));
  cpt_mul #(.WA(DtW), .WB(DtW)) u_va1 (
    .clk_i (clk_i), .en_i (en), .a_i (d_q[4]), .b_i (d_q[3]), .p_o (vp[1]));
  cpt_mul #(.WA(DtW), .WB(DtW)) u_vb0 (
    .clk_i (clk_i), .en_i (en), .a_i (d_q[4]), .b_i (d_q[1]), .p_o (vp[2]));
  cpt_mul #(.WA(DtW), .WB(DtW)) u_vb1 (
    .clk_i (clk_i), .en_i (en), .a_i (d_q[0]), .b_i (d_q[5]), .p_o (vp[3]));
  cpt_mul #(.WA(DtW), .WB(DtW)) u_vc0 (
    .clk_i (clk_i), .en_i (en), .a_i (d_q[0]), .b_i (d_q[3]), .p_o (vp[4]));
  cpt_mul #(.WA(DtW), .WB(DtW)) u_vc1 (
    .clk_i (clk_i), .en_i (en), .a_i (d_q[2]), .b_i (d_q[1]), .p_o (vp[5]));

  // Stage 3: va, vb, vc.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        v_q[k] <= VW'(vp[2*k]) - VW'(vp[2*k+1]);
      end
    end
  end

  // The dot products wait for the barycentric terms.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      d_flat[k*DtW +: DtW] = d_q[k];
      dd[k] = $signed(dd_flat[k*DtW +: DtW]);
    end
  end

  cpt_dly #(.W(6 * DtW), .N(cpt_pkg::LatMulV + 1)) u_dly_d (
    .clk_i (clk_i), .en_i (en), .d_i (d_flat), .q_o (dd_flat));

  // Edge vectors and vertices wait for the region decision.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      df_flat[(0*3+i)*DfW +: DfW] = ab_q[i];
      df_flat[(1*3+i)*DfW +: DfW] = ac_q[i];
      df_flat[(2*3+i)*DfW +: DfW] = bc_q[i];
      cr_flat[(0*3+i)*CW +: CW]   = a_q[i];
      cr_flat[(1*3+i)*CW +: CW]   = b_q[i];
      cr_flat[(2*3+i)*CW +: CW]   = c_q[i];
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        dfl[k][i] = $signed(dfl_flat[(k*3+i)*DfW +: DfW]);
        crl[k][i] = $signed(crl_flat[(k*3+i)*CW +: CW]);
      end
    end
  end

  cpt_dly #(.W(9 * DfW), .N(cpt_pkg::LatMulDot + cpt_pkg::LatMulV + 3)) u_dly_df (
    .clk_i (clk_i), .en_i (en), .d_i (df_flat), .q_o (dfl_flat));
  cpt_dly #(.W(9 * CW), .N(cpt_pkg::LatMulDot + cpt_pkg::LatMulV + 3)) u_dly_cr (
    .clk_i (clk_i), .en_i (en), .d_i (cr_flat), .q_o (crl_flat));

  // Candidate divisors and the edge-BC parameter.
  assign t_w   = D1W'(dd[3]) - D1W'(dd[2]);
  assign e5_w  = D1W'(dd[4]) - D1W'(dd[5]);
  assign dab_w = D1W'(dd[0]) - D1W'(dd[2]);
  assign dac_w = D1W'(dd[1]) - D1W'(dd[5]);
  assign dbc_w = D2W'(t_w) + D2W'(e5_w);
  assign din_w = DnW'(v_q[0]) + DnW'(v_q[1]) + DnW'(v_q[2]);

  // Voronoi region tests in their fixed order.
  always_comb begin
    priority if (dd[0] <= 0 && dd[1] <= 0) begin
      r1_code_d = cpt_pkg::RegVertA;
      r1_den_d  = '0;
      r1_x1_d   = '0;
      r1_x2_d   = '0;
    end else if (dd[2] >= 0 && dd[3] <= dd[2]) begin
      r1_code_d = cpt_pkg::RegVertB;
      r1_den_d  = '0;
      r1_x1_d   = '0;
      r1_x2_d   = '0;
    end else if (v_q[2] <= 0 && dd[0] >= 0 && dd[2] <= 0) begin
      r1_code_d = cpt_pkg::RegEdgeAB;
      r1_den_d  = DnW'(dab_w);
      r1_x1_d   = VW'(dd[0]);
      r1_x2_d   = '0;
    end else if (dd[5] >= 0 && dd[4] <= dd[5]) begin
      r1_code_d = cpt_pkg::RegVertC;
      r1_den_d  = '0;
      r1_x1_d   = '0;
      r1_x2_d   = '0;
    end else if (v_q[1] <= 0 && dd[1] >= 0 && dd[5] <= 0) begin
      r1_code_d = cpt_pkg::RegEdgeAC;
      r1_den_d  = DnW'(dac_w);
      r1_x1_d   = VW'(dd[1]);
      r1_x2_d   = '0;
    end else if (v_q[0] <= 0 && dd[3] >= dd[2] && dd[4] >= dd[5]) begin
      r1_code_d = cpt_pkg::RegEdgeBC;
      r1_den_d  = DnW'(dbc_w);
      r1_x1_d   = VW'(t_w);
      r1_x2_d   = '0;
    end else begin
      r1_code_d = cpt_pkg::RegInterior;
      r1_den_d  = din_w;
      r1_x1_d   = v_q[1];
      r1_x2_d   = v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_code_q <= r1_code_d;
      r1_den_q  <= r1_den_d;
      r1_x1_q   <= r1_x1_d;
      r1_x2_q   <= r1_x2_d;
    end
  end

  // A zero edge or interior divisor falls back to vertex A, coded as degenerate.
  assign den_zero = (r1_den_q == '0);

  always_comb begin
    r2_code_d = r1_code_q;
    r2_addq_d = 1'b0;
    r2_esel   = 2'd0;
    r2_bsel   = 2'd0;
    unique case (r1_code_q)
      cpt_pkg::RegVertA: begin
        r2_bsel = 2'd0;
      end
      cpt_pkg::RegVertB: begin
        r2_bsel = 2'd1;
      end
      cpt_pkg::RegVertC: begin
        r2_bsel = 2'd2;
      end
      cpt_pkg::RegEdgeAB, cpt_pkg::RegInterior: begin
        r2_addq_d = !den_zero;
        r2_code_d = den_zero ? cpt_pkg::RegDegen : r1_code_q;
      end
      cpt_pkg::RegEdgeAC: begin
        r2_esel   = 2'd1;
        r2_addq_d = !den_zero;
        r2_code_d = den_zero ? cpt_pkg::RegDegen : r1_code_q;
      end
      cpt_pkg::RegEdgeBC: begin
        r2_esel   = 2'd2;
        r2_bsel   = den_zero ? 2'd0 : 2'd1;
        r2_addq_d = !den_zero;
        r2_code_d = den_zero ? cpt_pkg::RegDegen : r1_code_q;
      end
      default: begin
        r2_code_d = cpt_pkg::RegDegen;
      end
    endcase
  end

  // Stage 5: multiplier operands, divisor and base point.
  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_code_q <= r2_code_d;
      r2_addq_q <= r2_addq_d;
      r2_x1_q   <= r1_x1_q;
      r2_x2_q   <= r1_x2_q;
      r2_den_q  <= r1_den_q;
      for (int i = 0; i < 3; i++) begin
        r2_e1_q[i]   <= dfl[r2_esel][i];
        r2_e2_q[i]   <= dfl[1][i];
        r2_base_q[i] <= crl[r2_bsel][i];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_num
    cpt_mul #(.WA(VW), .WB(DfW)) u_m1 (
      .clk_i (clk_i), .en_i (en), .a_i (r2_x1_q), .b_i (r2_e1_q[i]), .p_o (m1[i]));
    cpt_mul #(.WA(VW), .WB(DfW)) u_m2 (
      .clk_i (clk_i), .en_i (en), .a_i (r2_x2_q), .b_i (r2_e2_q[i]), .p_o (m2[i]));

    // Stage 6: numerator.
    always_ff @(posedge clk_i) begin
      if (en) begin
        num_q[i] <= NW'(m1[i]) + NW'(m2[i]);
      end
    end

    cpt_div #(.WN(NW), .WD(DnW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[i]),
      .den_i ($signed(den_l)),
      .quo_o (quo[i])
    );
  end

  cpt_dly #(.W(DnW), .N(cpt_pkg::LatMulNum + 1)) u_dly_den (
    .clk_i (clk_i), .en_i (en), .d_i (r2_den_q), .q_o (den_l));

  // Base point and code wait for the quotient.
  assign side_d = {r2_base_q[2], r2_base_q[1], r2_base_q[0], r2_code_q, r2_addq_q};

  cpt_dly #(.W(SideW), .N(cpt_pkg::LatMulNum + 1 + cpt_pkg::LatDiv)) u_dly_side (
    .clk_i (clk_i), .en_i (en), .d_i (side_d), .q_o (side_l));

  always_comb begin
    addq_l = side_l[0];
    code_l = side_l[3:1];
    for (int i = 0; i < 3; i++) begin
      base_l[i] = $signed(side_l[4 + i*CW +: CW]);
      sum_w[i]  = addq_l ? SW'(base_l[i]) + SW'(quo[i]) : SW'(base_l[i]);
      if (sum_w[i] > SW'(32'sh7FFF_FFFF)) begin
        sat_w[i] = 32'sh7FFF_FFFF;
      end else if (sum_w[i] < SW'(32'sh8000_0000)) begin
        sat_w[i] = 32'sh8000_0000;
      end else begin
        sat_w[i] = sum_w[i][CW-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      near_x_o <= sat_w[0];
      near_y_o <= sat_w[1];
      near_z_o <= sat_w[2];
      region_o <= code_l;
    end
  end

endmodule

### sv/cpt_chk.sv
// Port-level checker for the closest-point-on-triangle block, bound to its top level.
module cpt_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] near_x_o,
  input logic [2:0]         region_o
);

  // The input is stalled only while a finished beat is held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output beat");

  // A held output beat always stalls the input.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output beat is held");

  // A stalled result beat holds its valid bit, region code and x coordinate.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(region_o) && $stable(near_x_o)))
    else $error("stalled output beat changed");

  // No result during reset.
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind closest_point_on_triangle cpt_chk u_cpt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .near_x_o    (near_x_o),
  .region_o    (region_o)
);
